// ----- sv/gfp_pkg.sv -----
// Package for the growable free-list item pool.
// Types, codes and constants shared by the controller, datapath and top level.
`default_nettype none
package gfp_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  localparam logic [1:0] KIND_GET = 2'd0;
  localparam logic [1:0] KIND_PUT = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;
  localparam logic [1:0] KIND_PUT_ALL = 2'd3;

  localparam logic [1:0] REG_INITIAL_ITEMS = 2'd0;
  localparam logic [1:0] REG_GROW_STEP = 2'd1;
  localparam logic [1:0] REG_GROW_LIMIT = 2'd2;

  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_ITEM = 2'd1;
  localparam logic [1:0] RES_HEAD = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [IDX_W-1:0] item_index;
  } gfp_in_t;

  typedef struct packed {
    logic ok;
    logic [IDX_W-1:0] result_index;
    logic did_grow;
    logic [CNT_W-1:0] free_items;
    logic [CNT_W-1:0] total_items;
  } gfp_out_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic get_pop;
    logic get_load;
    logic get_link;
    logic get_fin;
    logic rd_idx;
    logic put_fin;
    logic all_step;
    logic emit;
    logic emit_ok;
    logic [1:0] res_sel;
  } gfp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic get_fail;
    logic from_stack;
    logic used_empty;
    logic flag_hit;
  } gfp_sts_t;

endpackage
`default_nettype wire

// ----- sv/gfp_ctrl.sv -----
// Controller state machine of the item pool.
// Sequences get, put, peek, put-all and the flag clearing sweep; uses gfp_pkg.
`default_nettype none
module gfp_ctrl import gfp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic [1:0] kind,
  input  wire logic     cfg_init,
  input  wire gfp_sts_t sts,
  output gfp_cmd_t      cmd,
  output logic          busy
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR = 4'd1;
  localparam logic [3:0] S_G0 = 4'd2;
  localparam logic [3:0] S_G1 = 4'd3;
  localparam logic [3:0] S_G2 = 4'd4;
  localparam logic [3:0] S_G3 = 4'd5;
  localparam logic [3:0] S_P0 = 4'd6;
  localparam logic [3:0] S_P1 = 4'd7;
  localparam logic [3:0] S_PK = 4'd8;
  localparam logic [3:0] S_A0 = 4'd9;
  localparam logic [3:0] S_A1 = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (cfg_init) begin
          state_nxt = S_CLR;
        end else if (start) begin
          cmd.load = 1'b1;
          case (kind)
            KIND_GET: state_nxt = S_G0;
            KIND_PUT: state_nxt = S_P0;
            KIND_PEEK: state_nxt = S_PK;
            default: state_nxt = S_A0;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_G0: begin
        if (sts.get_fail) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.get_pop = 1'b1;
          state_nxt = sts.from_stack ? S_G1 : S_G2;
        end
      end
      S_G1: begin
        cmd.get_load = 1'b1;
        state_nxt = S_G2;
      end
      S_G2: begin
        cmd.get_link = 1'b1;
        state_nxt = S_G3;
      end
      S_G3: begin
        cmd.get_fin = 1'b1;
        cmd.emit = 1'b1;
        cmd.emit_ok = 1'b1;
        cmd.res_sel = RES_ITEM;
        state_nxt = S_IDLE;
      end
      S_P0: begin
        cmd.rd_idx = 1'b1;
        state_nxt = S_P1;
      end
      S_P1: begin
        cmd.put_fin = sts.flag_hit;
        cmd.emit = 1'b1;
        cmd.emit_ok = sts.flag_hit;
        state_nxt = S_IDLE;
      end
      S_PK: begin
        cmd.emit = 1'b1;
        cmd.emit_ok = !sts.used_empty;
        cmd.res_sel = sts.used_empty ? RES_ZERO : RES_HEAD;
        state_nxt = S_IDLE;
      end
      S_A0: begin
        if (sts.used_empty) begin
          cmd.emit = 1'b1;
          cmd.emit_ok = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_A1;
        end
      end
      S_A1: begin
        cmd.all_step = 1'b1;
        state_nxt = S_A0;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/gfp_dpath.sv -----
// Datapath of the item pool: configuration, counters, list pointers and memories.
// Executes commands from gfp_ctrl and reports status; uses gfp_pkg.
`default_nettype none
module gfp_dpath import gfp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire gfp_cmd_t         cmd,
  input  wire gfp_in_t          in_item,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CNT_W-1:0] cfg_data,
  output gfp_sts_t              sts,
  output logic                  out_valid,
  output gfp_out_t              out_item
);

  logic [IDX_W-1:0] free_stack [CAPACITY];
  logic [IDX_W-1:0] used_next [CAPACITY];
  logic [IDX_W-1:0] used_prev [CAPACITY];
  logic used_flag [CAPACITY];

  logic [CNT_W-1:0] step_r;
  logic [7:0] limit_r;
  logic [CNT_W-1:0] rd_r, rd_nxt, fresh_r, fresh_nxt, total_r, total_nxt;
  logic [CNT_W-1:0] base_r, base_nxt, count_r, count_nxt;
  logic [7:0] grows_r, grows_nxt;
  logic [IDX_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt, item_r, item_nxt, clr_r;
  logic grew_r, grew_nxt;
  logic out_valid_r;
  gfp_out_t out_r;

  logic [IDX_W-1:0] stack_q, next_q, prev_q;
  logic flag_q;
  logic [IDX_W-1:0] used_raddr, stack_raddr;

  logic stack_we, next_we, prev_we, flag_we, flag_d;
  logic [IDX_W-1:0] stack_wa, next_wa, prev_wa, flag_wa, stack_d, next_d, prev_d;

  logic [CNT_W-1:0] room, add, fr_eff, base_eff, init_clamp;
  logic need_grow, grow_ok, cfg_init;

  assign cfg_init = cfg_we && (cfg_index == REG_INITIAL_ITEMS);
  assign init_clamp = (cfg_data > CAP_COUNT) ? CAP_COUNT : cfg_data;

  assign room = CAP_COUNT - total_r;
  assign add = (step_r < room) ? step_r : room;
  assign need_grow = (rd_r == '0) && (fresh_r == '0);
  assign grow_ok = (grows_r < limit_r) && (add != '0);
  assign fr_eff = need_grow ? add : fresh_r;
  assign base_eff = need_grow ? total_r : base_r;

  assign sts.clr_done = (clr_r == IDX_W'(CAPACITY - 1));
  assign sts.get_fail = need_grow && !grow_ok;
  assign sts.from_stack = (rd_r != '0);
  assign sts.used_empty = (count_r == '0);
  assign sts.flag_hit = flag_q;

  assign used_raddr = cmd.rd_idx ? idx_r : head_r;
  assign stack_raddr = IDX_W'(rd_r - CNT_W'(1));

  always_comb begin
    rd_nxt = rd_r;
    fresh_nxt = fresh_r;
    total_nxt = total_r;
    base_nxt = base_r;
    count_nxt = count_r;
    grows_nxt = grows_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    idx_nxt = idx_r;
    item_nxt = item_r;
    grew_nxt = grew_r;
    stack_we = 1'b0;
    stack_wa = IDX_W'(rd_r);
    stack_d = head_r;
    next_we = 1'b0;
    next_wa = item_r;
    next_d = head_r;
    prev_we = 1'b0;
    prev_wa = head_r;
    prev_d = item_r;
    flag_we = 1'b0;
    flag_wa = item_r;
    flag_d = 1'b0;

    if (cmd.load) begin
      idx_nxt = in_item.item_index;
      grew_nxt = 1'b0;
    end
    if (cmd.clr) begin
      flag_we = 1'b1;
      flag_wa = clr_r;
    end
    if (cmd.get_pop) begin
      if (need_grow) begin
        base_nxt = total_r;
        total_nxt = total_r + add;
        grows_nxt = grows_r + 8'd1;
        grew_nxt = 1'b1;
      end
      if (rd_r != '0) begin
        rd_nxt = rd_r - CNT_W'(1);
      end else begin
        fresh_nxt = fr_eff - CNT_W'(1);
        item_nxt = IDX_W'(base_eff + fr_eff - CNT_W'(1));
      end
    end
    if (cmd.get_load) begin
      item_nxt = stack_q;
    end
    if (cmd.get_link) begin
      prev_we = (count_r != '0);
      next_we = 1'b1;
      flag_we = 1'b1;
      flag_d = 1'b1;
    end
    if (cmd.get_fin) begin
      prev_we = 1'b1;
      prev_wa = item_r;
      prev_d = '0;
      head_nxt = item_r;
      if (count_r == '0) tail_nxt = item_r;
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.put_fin) begin
      if (count_r <= CNT_W'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end else if (idx_r == head_r) begin
        head_nxt = next_q;
      end else begin
        next_we = 1'b1;
        next_wa = prev_q;
        next_d = next_q;
        if (idx_r == tail_r) begin
          tail_nxt = prev_q;
        end else begin
          prev_we = 1'b1;
          prev_wa = next_q;
          prev_d = prev_q;
        end
      end
      flag_we = 1'b1;
      flag_wa = idx_r;
      stack_we = 1'b1;
      stack_d = idx_r;
      rd_nxt = rd_r + CNT_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.all_step) begin
      if (count_r <= CNT_W'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end else begin
        head_nxt = next_q;
      end
      flag_we = 1'b1;
      flag_wa = head_r;
      stack_we = 1'b1;
      stack_d = head_r;
      rd_nxt = rd_r + CNT_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) free_stack[stack_wa] <= stack_d;
    stack_q <= free_stack[stack_raddr];
  end

  always_ff @(posedge clk) begin
    if (next_we) used_next[next_wa] <= next_d;
    next_q <= used_next[used_raddr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) used_prev[prev_wa] <= prev_d;
    prev_q <= used_prev[used_raddr];
  end

  always_ff @(posedge clk) begin
    if (flag_we) used_flag[flag_wa] <= flag_d;
    flag_q <= used_flag[used_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      limit_r <= '0;
      rd_r <= '0;
      fresh_r <= CNT_W'(16);
      total_r <= CNT_W'(16);
      base_r <= '0;
      grows_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
      clr_r <= '0;
      grew_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (cfg_init) begin
      rd_r <= '0;
      fresh_r <= init_clamp;
      total_r <= init_clamp;
      base_r <= '0;
      grows_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_GROW_STEP) step_r <= cfg_data;
      if (cfg_we && cfg_index == REG_GROW_LIMIT) limit_r <= cfg_data[7:0];
      rd_r <= rd_nxt;
      fresh_r <= fresh_nxt;
      total_r <= total_nxt;
      base_r <= base_nxt;
      grows_r <= grows_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      count_r <= count_nxt;
      grew_r <= grew_nxt;
      if (cmd.clr) clr_r <= clr_r + IDX_W'(1);
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    item_r <= item_nxt;
    if (cmd.emit) begin
      out_r.ok <= cmd.emit_ok;
      case (cmd.res_sel)
        RES_ITEM: out_r.result_index <= item_r;
        RES_HEAD: out_r.result_index <= head_r;
        default: out_r.result_index <= '0;
      endcase
      out_r.did_grow <= grew_nxt;
      out_r.free_items <= rd_nxt + fresh_nxt;
      out_r.total_items <= total_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;

endmodule
`default_nettype wire

// ----- sv/growable_free_list_item_pool.sv -----
// Growable free-list item pool: top level joining gfp_ctrl and gfp_dpath.
// A get from returned items adds a free-stack read to one from fresh items; a failed get
// ends without touching the lists. Put all walks the in-use list, with one list-memory read
// and one write per step.
// One item at a time: busy stays high from accept until the result strobe.
// Reset and a write of initial_items run a flag clearing sweep over all 1024 entries with busy high.
`default_nettype none
module growable_free_list_item_pool import gfp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire gfp_in_t          in_item,
  output logic                  out_valid,
  output gfp_out_t              out_item,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CNT_W-1:0] cfg_data
);

  gfp_cmd_t cmd;
  gfp_sts_t sts;
  logic cfg_init;

  assign cfg_init = cfg_we && (cfg_index == REG_INITIAL_ITEMS);

  gfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .kind     (in_item.kind),
    .cfg_init (cfg_init),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  gfp_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ----- sv/gfp_checker.sv -----
// Port-level checker for the item pool, bound to growable_free_list_item_pool.
// Uses gfp_pkg for types and the capacity constant.
`default_nettype none
module gfp_assert import gfp_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire gfp_out_t out_item
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_free_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.free_items <= out_item.total_items)
    else $error("free count above total");

  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.total_items <= CAP_COUNT)
    else $error("total above capacity");

  a_grow_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.did_grow |-> out_item.ok)
    else $error("growth reported on failed item");

endmodule

bind growable_free_list_item_pool gfp_assert u_gfp_assert (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire
